FILE: sv/tdesm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the table-driven event state machine
// used by tdesm_cell and table_driven_event_state_machine; no dependencies

package tdesm_pkg;

   localparam int TDESM_NUM_TRANSITIONS = 16;
   localparam int TDESM_INDEX_W         = 4;
   localparam int TDESM_SLOT_LIMIT      = 2 ** TDESM_INDEX_W;
   localparam int TDESM_STATE_W         = 8;
   localparam int TDESM_EVENT_W         = 16;
   localparam int TDESM_REASON_W        = 16;
   localparam int TDESM_GUARD_W         = 16;
   localparam int TDESM_ADDR_W          = 3;

   localparam logic [1:0] FUNC_LOAD     = 2'd0;
   localparam logic [1:0] FUNC_DISPATCH = 2'd1;
   localparam logic [1:0] FUNC_RESTART  = 2'd2;

   localparam logic CSR_IDX_HOME_STATE = 1'b0;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_MATCH = 1'b1;

   typedef struct packed {
      logic                      valid;
      logic [TDESM_STATE_W-1:0]  src_state;
      logic                      from_any;
      logic [TDESM_EVENT_W-1:0]  event_code;
      logic                      event_any;
      logic [TDESM_STATE_W-1:0]  dst_state;
      logic                      internal;
      logic [TDESM_REASON_W-1:0] reason;
      logic                      has_guard;
   } entry_type;

   // dispatch word travelling down the row of cells
   typedef struct packed {
      logic                      active;
      logic                      found;
      logic [TDESM_EVENT_W-1:0]  event_code;
      logic [TDESM_GUARD_W-1:0]  guards;
      logic [TDESM_STATE_W-1:0]  cur_state;
      logic [TDESM_STATE_W-1:0]  dst_state;
      logic [TDESM_REASON_W-1:0] reason;
      logic                      internal;
      logic [TDESM_INDEX_W-1:0]  index;
   } token_type;

endpackage

FILE: sv/tdesm_cell.sv
`timescale 1ns / 1ps
// one table slot: holds a transition entry and checks the passing dispatch word
// depends on tdesm_pkg

module tdesm_cell #(
   parameter int IDX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  tdesm_pkg::entry_type wr_entry,
   input  tdesm_pkg::token_type tok_in,
   output tdesm_pkg::token_type tok_out
);
   import tdesm_pkg::*;

   entry_type entry_ff;
   token_type tok_ff;
   token_type tok_in_w;
   logic      hit;

   always_comb begin
      hit = tok_in.active && !tok_in.found && entry_ff.valid
         && (entry_ff.from_any || (entry_ff.src_state == tok_in.cur_state))
         && (entry_ff.event_any || (entry_ff.event_code == tok_in.event_code))
         && (!entry_ff.has_guard || tok_in.guards[0]);
      tok_in_w = tok_in;
      // next cell sees its own guard bit at position zero
      tok_in_w.guards = {1'b0, tok_in.guards[TDESM_GUARD_W-1:1]};
      if (hit) begin
         tok_in_w.found     = 1'b1;
         tok_in_w.dst_state = entry_ff.dst_state;
         tok_in_w.reason    = entry_ff.reason;
         tok_in_w.internal  = entry_ff.internal;
         tok_in_w.index     = TDESM_INDEX_W'(IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         tok_ff.active  <= 1'b0;
      end else begin
         if (wr_en) begin
            entry_ff <= wr_entry;
         end
         tok_ff <= tok_in_w;
      end
   end

   assign tok_out = tok_ff;

endmodule

FILE: sv/table_driven_event_state_machine.sv
`timescale 1ns / 1ps
// top level of the table-driven event state machine: item decode, state register,
// config port and the row of tdesm_cell slots; depends on tdesm_pkg and tdesm_cell

// usage
// - an item word is taken when start is high and busy is low; req_func selects
//   load entry, dispatch event or restart
// - each item gives one result word, shown on the rsp_ ports for one cycle
//   while rsp_valid is high; the receiver cannot hold it off
// - load, restart and unused codes: result in the cycle after acceptance,
//   next item may be taken at once
// - dispatch: the event word walks the row of cells, one slot per cycle,
//   through the head register and each slot's register in turn; busy stays
//   high until the result word is registered, so the row length sets the wait
// - the first matching valid slot in index order wins; later slots pass it on
// - config port: home state register at byte address 0, written in the access
//   phase of an apb write; pready is tied high, reads return the register
// - synchronous reset clears all slot valid bits, the home state register and
//   the current state to zero; no clearing pass is needed
// - slots at index 16 and above cannot be loaded and stay empty

module table_driven_event_state_machine #(
   parameter int NUM_TRANSITIONS = tdesm_pkg::TDESM_NUM_TRANSITIONS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_func,
   input  logic [tdesm_pkg::TDESM_INDEX_W-1:0]  req_entry_index,
   input  logic                                 req_entry_valid,
   input  logic [tdesm_pkg::TDESM_STATE_W-1:0]  req_src_state,
   input  logic                                 req_from_any,
   input  logic [tdesm_pkg::TDESM_EVENT_W-1:0]  req_event_code,
   input  logic                                 req_event_any,
   input  logic [tdesm_pkg::TDESM_STATE_W-1:0]  req_dst_state,
   input  logic                                 req_internal,
   input  logic [tdesm_pkg::TDESM_REASON_W-1:0] req_reason,
   input  logic                                 req_has_guard,
   input  logic [tdesm_pkg::TDESM_GUARD_W-1:0]  req_guard_pass,
   output logic                                 rsp_valid,
   output logic                                 rsp_status,
   output logic [tdesm_pkg::TDESM_STATE_W-1:0]  rsp_prior_state,
   output logic [tdesm_pkg::TDESM_STATE_W-1:0]  rsp_new_state,
   output logic [tdesm_pkg::TDESM_INDEX_W-1:0]  rsp_matched_index,
   output logic [tdesm_pkg::TDESM_REASON_W-1:0] rsp_taken_reason,
   output logic                                 rsp_exit_hook,
   output logic                                 rsp_entry_hook,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [tdesm_pkg::TDESM_ADDR_W-1:0]   paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import tdesm_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type                 state_ff;
   logic [TDESM_STATE_W-1:0]  cur_state_ff;
   logic [TDESM_STATE_W-1:0]  init_state_ff;
   token_type                 head_ff;
   token_type                 head_in;

   logic                      rsp_valid_ff;
   logic                      rsp_status_ff;
   logic [TDESM_STATE_W-1:0]  rsp_prev_ff;
   logic [TDESM_STATE_W-1:0]  rsp_new_ff;
   logic [TDESM_INDEX_W-1:0]  rsp_index_ff;
   logic [TDESM_REASON_W-1:0] rsp_reason_ff;
   logic                      rsp_hook_ff;

   token_type                 chain [NUM_TRANSITIONS+1];
   token_type                 tail;
   logic [NUM_TRANSITIONS-1:0] wr_en;
   entry_type                 wr_entry;
   logic                      accept;
   logic                      load_accept;
   logic                      csr_write;
   logic                      csr_index;

   assign accept      = start && (state_ff == ST_IDLE);
   assign load_accept = accept && (req_func == FUNC_LOAD);
   assign busy        = (state_ff == ST_SCAN);

   // config port, register index taken from the word address bit
   assign pready    = 1'b1;
   assign csr_index = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (csr_index == CSR_IDX_HOME_STATE)
                      ? {{(32-TDESM_STATE_W){1'b0}}, init_state_ff} : 32'd0;

   // entry word written by a load item
   always_comb begin
      wr_entry.valid      = req_entry_valid;
      wr_entry.src_state  = req_src_state;
      wr_entry.from_any   = req_from_any;
      wr_entry.event_code = req_event_code;
      wr_entry.event_any  = req_event_any;
      wr_entry.dst_state  = req_dst_state;
      wr_entry.internal   = req_internal;
      wr_entry.reason     = req_reason;
      wr_entry.has_guard  = req_has_guard;
   end

   // fresh dispatch word for the head of the row
   always_comb begin
      head_in            = '0;
      head_in.active     = accept && (req_func == FUNC_DISPATCH);
      head_in.event_code = req_event_code;
      head_in.guards     = req_guard_pass;
      head_in.cur_state  = cur_state_ff;
   end

   assign chain[0] = head_ff;

   // row of slots, each one passing the dispatch word to the next
   for (genvar g = 0; g < NUM_TRANSITIONS; g++) begin : g_cell
      if (g < TDESM_SLOT_LIMIT) begin : g_loadable
         assign wr_en[g] = load_accept && (req_entry_index == TDESM_INDEX_W'(g));
      end else begin : g_fixed
         assign wr_en[g] = 1'b0;
      end
      tdesm_cell #(
         .IDX (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (wr_en[g]),
         .wr_entry (wr_entry),
         .tok_in   (chain[g]),
         .tok_out  (chain[g+1])
      );
   end

   assign tail = chain[NUM_TRANSITIONS];

   // control, current state and result word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cur_state_ff   <= '0;
         init_state_ff  <= '0;
         head_ff.active <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         head_ff      <= head_in;
         rsp_valid_ff <= 1'b0;
         if (csr_write && (csr_index == CSR_IDX_HOME_STATE)) begin
            init_state_ff <= pwdata[TDESM_STATE_W-1:0];
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rsp_prev_ff   <= cur_state_ff;
                  rsp_status_ff <= STATUS_OK;
                  rsp_index_ff  <= '0;
                  rsp_reason_ff <= '0;
                  rsp_hook_ff   <= 1'b0;
                  if (req_func == FUNC_DISPATCH) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     // load, restart and unused codes answer at once
                     rsp_valid_ff <= 1'b1;
                     if (req_func == FUNC_RESTART) begin
                        cur_state_ff <= init_state_ff;
                        rsp_new_ff   <= init_state_ff;
                     end else begin
                        rsp_new_ff <= cur_state_ff;
                     end
                  end
               end
            end
            ST_SCAN: begin
               // word has left the last slot
               if (tail.active) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
                  if (tail.found) begin
                     cur_state_ff  <= tail.dst_state;
                     rsp_new_ff    <= tail.dst_state;
                     rsp_status_ff <= STATUS_OK;
                     rsp_index_ff  <= tail.index;
                     rsp_reason_ff <= tail.reason;
                     rsp_hook_ff   <= !tail.internal;
                  end else begin
                     rsp_new_ff    <= cur_state_ff;
                     rsp_status_ff <= STATUS_NO_MATCH;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_prior_state   = rsp_prev_ff;
   assign rsp_new_state     = rsp_new_ff;
   assign rsp_matched_index = rsp_index_ff;
   assign rsp_taken_reason  = rsp_reason_ff;
   assign rsp_exit_hook     = rsp_hook_ff;
   assign rsp_entry_hook    = rsp_hook_ff;

   // no result word is shown while a dispatch walks the row
   a_no_rsp_in_scan: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("result shown during dispatch scan");

   // a dispatch word only leaves the row while scanning
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail.active |-> (state_ff == ST_SCAN))
      else $error("dispatch word outside scan");

   // a load writes at most one slot
   a_one_slot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(wr_en))
      else $error("several slots written at once");

   // a miss leaves the state where it was
   a_miss_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_NO_MATCH))
      |-> ((rsp_new_state == rsp_prior_state) && !rsp_exit_hook))
      else $error("miss changed the state");

   // leaving the scan always produces a result word
   a_scan_ends_rsp: assert property (@(posedge clock) disable iff (reset)
      (busy && tail.active) |=> rsp_valid)
      else $error("scan ended without result");

endmodule
